// File: hw/rtl/sake_pkg.sv
// Shared types, constants and arithmetic helpers for the speed/accel estimator
`timescale 1ns / 1ps
package sake_pkg;

  localparam int FRAC_BITS = 20;
  localparam int DT_BITS   = 24;
  localparam logic signed [63:0] ONE_Q20 = 64'sd1048576;
  localparam logic signed [63:0] LIM64   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NLIM64  = -64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic [62:0] PN_RESET = 63'd104858;
  localparam logic [62:0] SN_RESET = 63'd104857600;
  localparam logic [62:0] AN_RESET = 63'd1048576000000000000;

  typedef enum logic [1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_SPEED_NOISE   = 2'd1,
    REG_ACCEL_NOISE   = 2'd2
  } cfg_reg_t;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // register file slots in the datapath
  typedef enum logic [4:0] {
    R_DT, R_SM, R_AM, R_PN, R_SN, R_AN,
    R_C0, R_C1, R_C2, R_C3, R_SPD, R_ACC, R_POS,
    R_PS, R_PA, R_DC3, R_P00, R_P01, R_P10, R_P11,
    R_D1, R_K00, R_K10, R_INN, R_S1, R_A1, R_OMK,
    R_Q00, R_Q01, R_Q10, R_Q11, R_T
  } slot_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_MUL20, OP_MUL24, OP_ADD, OP_SUB, OP_DIV,
    OP_SAT32_ADD, OP_SAT48_ADD, OP_MOV, OP_NOP
  } op_t;

  typedef struct packed {
    op_t   op;
    slot_t src_a;
    slot_t src_b;
    slot_t dst;
    logic  start;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ISSUE, S_WAIT, S_COMMIT, S_OUT
  } state_t;

  localparam int NUM_STEPS = 45;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef struct packed {
    op_t   op;
    slot_t a;
    slot_t b;
    slot_t d;
  } step_t;

  function automatic step_t program_step(input logic [STEP_W-1:0] i);
    step_t s;
    s = '{OP_NOP, R_T, R_T, R_T};
    unique case (i)
      6'd0:  s = '{OP_MUL24, R_ACC, R_DT, R_T};
      6'd1:  s = '{OP_SAT32_ADD, R_SPD, R_T, R_PS};
      6'd2:  s = '{OP_MOV, R_ACC, R_ACC, R_PA};
      6'd3:  s = '{OP_MUL24, R_DT, R_C3, R_DC3};
      6'd4:  s = '{OP_ADD, R_C1, R_C2, R_T};
      6'd5:  s = '{OP_MUL24, R_DT, R_T, R_T};
      6'd6:  s = '{OP_ADD, R_C0, R_T, R_P00};
      6'd7:  s = '{OP_MUL24, R_DT, R_DT, R_T};
      6'd8:  s = '{OP_MUL24, R_T, R_C3, R_T};
      6'd9:  s = '{OP_ADD, R_P00, R_T, R_P00};
      6'd10: s = '{OP_ADD, R_P00, R_PN, R_P00};
      6'd11: s = '{OP_ADD, R_C1, R_DC3, R_P01};
      6'd12: s = '{OP_ADD, R_C2, R_DC3, R_P10};
      6'd13: s = '{OP_ADD, R_C3, R_PN, R_P11};
      6'd14: s = '{OP_ADD, R_P00, R_SN, R_D1};
      6'd15: s = '{OP_DIV, R_P00, R_D1, R_K00};
      6'd16: s = '{OP_DIV, R_P10, R_D1, R_K10};
      6'd17: s = '{OP_SUB, R_SM, R_PS, R_INN};
      6'd18: s = '{OP_MUL20, R_K00, R_INN, R_T};
      6'd19: s = '{OP_SAT32_ADD, R_PS, R_T, R_S1};
      6'd20: s = '{OP_MUL20, R_K10, R_INN, R_T};
      6'd21: s = '{OP_SAT32_ADD, R_PA, R_T, R_A1};
      6'd22: s = '{OP_SUB, R_DT, R_K00, R_OMK}; // a is forced to one
      6'd23: s = '{OP_MUL20, R_OMK, R_P00, R_Q00};
      6'd24: s = '{OP_MUL20, R_OMK, R_P01, R_Q01};
      6'd25: s = '{OP_MUL20, R_K10, R_P00, R_T};
      6'd26: s = '{OP_SUB, R_P10, R_T, R_Q10};
      6'd27: s = '{OP_MUL20, R_K10, R_P01, R_T};
      6'd28: s = '{OP_SUB, R_P11, R_T, R_Q11};
      6'd29: s = '{OP_ADD, R_Q11, R_AN, R_D1};
      6'd30: s = '{OP_DIV, R_Q01, R_D1, R_K00};
      6'd31: s = '{OP_DIV, R_Q11, R_D1, R_K10};
      6'd32: s = '{OP_SUB, R_AM, R_A1, R_INN};
      6'd33: s = '{OP_MUL20, R_K00, R_INN, R_T};
      6'd34: s = '{OP_SAT32_ADD, R_S1, R_T, R_SPD};
      6'd35: s = '{OP_MUL20, R_K10, R_INN, R_T};
      6'd36: s = '{OP_SAT32_ADD, R_A1, R_T, R_ACC};
      6'd37: s = '{OP_MUL20, R_K00, R_Q10, R_T};
      6'd38: s = '{OP_SUB, R_Q00, R_T, R_C0};
      6'd39: s = '{OP_MUL20, R_K00, R_Q11, R_T};
      6'd40: s = '{OP_SUB, R_Q01, R_T, R_C1};
      6'd41: s = '{OP_MUL20, R_K10, R_Q10, R_T};
      6'd42: s = '{OP_SUB, R_Q10, R_T, R_C2};
      6'd43: s = '{OP_MUL20, R_K10, R_Q11, R_T};
      6'd44: s = '{OP_SUB, R_Q11, R_T, R_C3};
      default: s = '{OP_NOP, R_T, R_T, R_T};
    endcase
    return s;
  endfunction

  // magnitude-saturating add, limits +/-(2^63-1)
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(LIM64)) return LIM64;
    if (s < 65'(NLIM64)) return NLIM64;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(LIM64)) return LIM64;
    if (s < 65'(NLIM64)) return NLIM64;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

// File: hw/rtl/sake_if.sv
// Valid/ready channel interfaces for the estimator
`timescale 1ns / 1ps
interface sake_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] speed_meas;
  logic [31:0] accel_meas;
  logic [23:0] time_step;
  modport source (output valid, cmd, speed_meas, accel_meas, time_step, input ready);
  modport sink   (input valid, cmd, speed_meas, accel_meas, time_step, output ready);
endinterface

interface sake_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed_est;
  logic [31:0] accel_est;
  logic [47:0] position_est;
  modport source (output valid, speed_est, accel_est, position_est, input ready);
  modport sink   (input valid, speed_est, accel_est, position_est, output ready);
endinterface

interface sake_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sake_mul.sv
// Sequential 64x64 magnitude multiplier, one 32x32 partial product per cycle, rounded shift
`timescale 1ns / 1ps
module sake_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sh24,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic        done,
  output logic signed [63:0] res
);
  import sake_pkg::*;

  logic [63:0]  x_r, y_r;
  logic         neg_r, sh24_r;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   cnt_r;
  logic         run_r;
  logic [31:0]  xs, ys;
  logic [63:0]  pp;
  logic [127:0] rnd, hi_part;
  logic [63:0]  m;

  always_comb begin
    xs = cnt_r[1] ? x_r[63:32] : x_r[31:0];
    ys = cnt_r[0] ? y_r[63:32] : y_r[31:0];
  end
  always_ff @(posedge clk) pp <= 64'(xs) * 64'(ys);

  always_comb begin
    acc_nxt = acc_r;
    // partial products land in the cycle after selection
    if (cnt_r != 3'd0 && cnt_r <= 3'd4) begin
      unique case (cnt_r)
        3'd1: acc_nxt = acc_r + 128'(pp);
        3'd2: acc_nxt = acc_r + (128'(pp) << 32);
        3'd3: acc_nxt = acc_r + (128'(pp) << 32);
        3'd4: acc_nxt = acc_r + (128'(pp) << 64);
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_comb begin
    rnd = acc_r + (sh24_r ? (128'd1 << 23) : (128'd1 << 19));
    hi_part = sh24_r ? (rnd >> 24) : (rnd >> 20);
    if (hi_part[127:63] != '0) m = 64'(LIM64);
    else m = hi_part[63:0];
    res = neg_r ? -$signed(m) : $signed(m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x_r    <= mag64(a);
        y_r    <= mag64(b);
        neg_r  <= a[63] ^ b[63];
        sh24_r <= sh24;
        acc_r  <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/sake_div.sv
// Radix-2 restoring divider for the Q44.20 gain, one quotient bit per cycle
`timescale 1ns / 1ps
module sake_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic signed [63:0] n,
  input  logic signed [63:0] d,
  output logic        done,
  output logic signed [63:0] res
);
  import sake_pkg::*;

  logic [83:0] num_r;
  logic [63:0] den_r;
  logic [64:0] rem_r;
  logic [83:0] q_r;
  logic [6:0]  cnt_r;
  logic        run_r, neg_r, zero_r;
  logic [64:0] rsh, rsub;
  logic [63:0] ql, qm;

  always_comb begin
    rsh  = {rem_r[63:0], num_r[83]};
    rsub = rsh - 65'(den_r);
    ql = q_r[63:0];
    if (q_r[83:63] != '0) qm = 64'(LIM64);
    // hold at the limit when rounding up would cross it
    else if (rem_r[63:0] >= den_r - rem_r[63:0]) qm = (ql == 64'(LIM64)) ? ql : ql + 64'd1;
    else qm = ql;
    if (zero_r) res = ONE_Q20;
    else res = neg_r ? -$signed(qm) : $signed(qm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_r  <= {mag64(n), 20'd0};
        den_r  <= mag64(d);
        neg_r  <= n[63] ^ d[63];
        zero_r <= (d == 64'sd0);
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= 7'd84;
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (cnt_r == 7'd0 || zero_r) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end else begin
          num_r <= num_r << 1;
          if (!rsub[64]) begin
            rem_r <= rsub;
            q_r   <= {q_r[82:0], 1'b1};
          end else begin
            rem_r <= rsh;
            q_r   <= {q_r[82:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/sake_datapath.sv
// Register file, shared multiplier and divider, saturating adder
`timescale 1ns / 1ps
module sake_datapath (
  input  logic        clk,
  input  logic        rst_n,
  input  sake_pkg::dp_cmd_t cmd,
  output sake_pkg::dp_sts_t sts,
  input  logic        load,
  input  logic        clear,
  input  logic [31:0] speed_meas,
  input  logic [31:0] accel_meas,
  input  logic [23:0] time_step,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [62:0] cfg_data,
  output logic [31:0] speed_est,
  output logic [31:0] accel_est,
  output logic [47:0] position_est
);
  import sake_pkg::*;

  logic signed [63:0] rf_r [32];
  logic signed [63:0] va, vb, alu;
  logic               mul_done, div_done, alu_we;
  logic signed [63:0] mul_res, div_res;
  logic               pend_r;
  op_t                op_r;
  slot_t              dst_r;
  logic signed [64:0] wide;

  always_comb begin
    va = (cmd.op == OP_SUB && cmd.dst == R_OMK) ? ONE_Q20 : rf_r[cmd.src_a];
    vb = rf_r[cmd.src_b];
  end

  sake_mul u_mul (
    .clk(clk), .rst_n(rst_n),
    .start(cmd.start && (cmd.op == OP_MUL20 || cmd.op == OP_MUL24)),
    .sh24(cmd.op == OP_MUL24), .a(va), .b(vb), .done(mul_done), .res(mul_res)
  );

  sake_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && cmd.op == OP_DIV),
    .n(va), .d(vb), .done(div_done), .res(div_res)
  );

  always_comb begin
    alu_we = 1'b0;
    alu = va;
    wide = 65'(va) + 65'(vb);
    case (cmd.op)
      OP_ADD: begin alu = sadd(va, vb); alu_we = 1'b1; end
      OP_SUB: begin alu = ssub(va, vb); alu_we = 1'b1; end
      OP_MOV: begin alu = va; alu_we = 1'b1; end
      OP_SAT32_ADD: begin
        alu_we = 1'b1;
        if (wide > 65'sd2147483647) alu = 64'sd2147483647;
        else if (wide < -65'sd2147483648) alu = -64'sd2147483648;
        else alu = wide[63:0];
      end
      OP_SAT48_ADD: begin
        alu_we = 1'b1;
        if (wide > 65'sd140737488355327) alu = 64'sd140737488355327;
        else if (wide < -65'sd140737488355328) alu = -64'sd140737488355328;
        else alu = wide[63:0];
      end
      default: alu_we = 1'b0;
    endcase
  end

  assign sts.busy = pend_r && !(mul_done || div_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      rf_r[R_PN]  <= $signed({1'b0, PN_RESET});
      rf_r[R_SN]  <= $signed({1'b0, SN_RESET});
      rf_r[R_AN]  <= $signed({1'b0, AN_RESET});
      rf_r[R_SPD] <= '0; rf_r[R_ACC] <= '0; rf_r[R_POS] <= '0;
      rf_r[R_C0] <= ONE_Q20; rf_r[R_C1] <= '0; rf_r[R_C2] <= '0; rf_r[R_C3] <= ONE_Q20;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PROCESS_NOISE: rf_r[R_PN] <= $signed({1'b0, cfg_data});
          REG_SPEED_NOISE:   rf_r[R_SN] <= $signed({1'b0, cfg_data});
          REG_ACCEL_NOISE:   rf_r[R_AN] <= $signed({1'b0, cfg_data});
          default: ;
        endcase
      end
      if (clear) begin
        rf_r[R_SPD] <= '0; rf_r[R_ACC] <= '0; rf_r[R_POS] <= '0;
        rf_r[R_C0] <= ONE_Q20; rf_r[R_C1] <= '0; rf_r[R_C2] <= '0; rf_r[R_C3] <= ONE_Q20;
      end else if (load) begin
        rf_r[R_SM] <= 64'($signed(speed_meas));
        rf_r[R_AM] <= 64'($signed(accel_meas));
        rf_r[R_DT] <= $signed({40'd0, time_step});
      end else if (cmd.start) begin
        if (cmd.op == OP_MUL20 || cmd.op == OP_MUL24 || cmd.op == OP_DIV) begin
          pend_r <= 1'b1;
          dst_r  <= cmd.dst;
          op_r   <= cmd.op;
        end else if (alu_we) begin
          rf_r[cmd.dst] <= alu;
        end
      end else if (pend_r && (mul_done || div_done)) begin
        pend_r <= 1'b0;
        rf_r[dst_r] <= (op_r == OP_DIV) ? div_res : mul_res;
      end
    end
  end

  assign speed_est    = rf_r[R_SPD][31:0];
  assign accel_est    = rf_r[R_ACC][31:0];
  assign position_est = rf_r[R_POS][47:0];
endmodule

// File: hw/rtl/sake_ctrl.sv
// Sequencer stepping the update program through the datapath
`timescale 1ns / 1ps
module sake_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_cmd,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic load,
  output logic clear,
  output sake_pkg::dp_cmd_t cmd,
  input  sake_pkg::dp_sts_t sts
);
  import sake_pkg::*;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic              pos_r, pos_nxt;
  step_t             st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      pos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    st = program_step(pc_r);
    // position update runs after the covariance program
    if (pos_r) st = pc_r[0] ? step_t'{OP_SAT48_ADD, R_POS, R_T, R_POS}
                            : step_t'{OP_MUL24, R_SPD, R_DT, R_T};
    state_nxt = state_r;
    pc_nxt    = pc_r;
    pos_nxt   = pos_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    load      = 1'b0;
    clear     = 1'b0;
    cmd       = '{OP_NOP, R_T, R_T, R_T, 1'b0};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_CLEAR) begin
            clear = 1'b1;
            state_nxt = S_OUT;
          end else begin
            load = 1'b1;
            pc_nxt = '0;
            pos_nxt = 1'b0;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd = '{st.op, st.a, st.b, st.d, 1'b1};
        if (st.op == OP_MUL20 || st.op == OP_MUL24 || st.op == OP_DIV)
          state_nxt = S_WAIT;
        else
          state_nxt = S_COMMIT;
      end
      S_WAIT: begin
        if (!sts.busy) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_ISSUE;
        if (pos_r) begin
          if (pc_r[0]) state_nxt = S_OUT;
          else pc_nxt = pc_r + 1'b1;
        end else if (pc_r == STEP_W'(NUM_STEPS - 1)) begin
          pos_nxt = 1'b1;
          pc_nxt = '0;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/speed_accel_kalman_estimator.sv
// Top level of the two-state speed/acceleration Kalman estimator
//  channel  dir  handshake      word
//  in_      in   valid/ready    cmd, speed_meas, accel_meas, time_step
//  out_     out  valid/ready    speed_est, accel_est, position_est
//  cfg_     in   valid/ready    index, data (noise registers)
// An update raises out_valid once the whole program has run: 18 multiplies on the shared
// 32x32 multiplier, four gain divisions on the bit-serial divider (which stops early when the
// denominator is zero) and 25 add/move steps. A clear command raises out_valid the cycle after
// acceptance. Reset restores identity covariance and default noise.
// One word is in flight; input is held off until the result has been taken.
`timescale 1ns / 1ps
module speed_accel_kalman_estimator (
  input logic clk,
  input logic rst_n,
  sake_in_if.sink    in_ch,
  sake_out_if.source out_ch,
  sake_cfg_if.sink   cfg_ch
);
  import sake_pkg::*;

  dp_cmd_t dcmd;
  dp_sts_t dsts;
  logic    load, clear;

  assign cfg_ch.ready = 1'b1;

  sake_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load(load), .clear(clear), .cmd(dcmd), .sts(dsts)
  );

  sake_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts), .load(load), .clear(clear),
    .speed_meas(in_ch.speed_meas), .accel_meas(in_ch.accel_meas),
    .time_step(in_ch.time_step),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data[62:0]),
    .speed_est(out_ch.speed_est), .accel_est(out_ch.accel_est),
    .position_est(out_ch.position_est)
  );
endmodule
